/* rtl/core/cdrp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdrp_pkg
// Shared types and constants for the change driven report packetizer.
// ----------------------------------------------------------------------------
package cdrp_pkg;

  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [5:0] LEFT_GROUPS   = 6'h15;
  localparam logic [5:0] RIGHT_GROUPS  = 6'h2A;
  localparam logic [5:0] BUTTON_GROUPS = 6'h30;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  localparam int unsigned NUM_SLOTS = 9;
  localparam int unsigned SLOT_W    = 4;

  typedef enum logic [1:0] {
    CMD_STICK   = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_BUTTON  = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MIN_INT   = 2'd1,
    CFG_ANALOG    = 2'd2,
    CFG_MAX_INT   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [5:0]       mask;
    logic [3:0][15:0] stick;
    logic [1:0][15:0] trig;
    logic [1:0][5:0]  btn;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* rtl/core/cdrp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdrp_queue
// Short packet queue between front and back; holds captured packet contents.
// ----------------------------------------------------------------------------
module cdrp_queue
  import cdrp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire snap_t     push_data,
  input  wire logic      pop,
  output snap_t          head,
  output q_status_t      status
);

  snap_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);

endmodule
`default_nettype wire

/* rtl/core/cdrp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdrp_front
// Accepts items, tracks values and pending groups, applies the tick rules and
// queues a packet capture on each send.
// ----------------------------------------------------------------------------
module cdrp_front
  import cdrp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [14:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_cmd,
  input  wire logic              in_side,
  input  wire logic              in_axis_sel,
  input  wire logic [2:0]        in_button_index,
  input  wire logic              in_pressed,
  input  wire logic signed [15:0] in_sample,
  input  wire q_status_t         q_status,
  output logic                   q_push,
  output snap_t                  q_data
);

  logic [14:0]        thr_r;
  logic [9:0]         min_r, analog_r, max_r;
  logic [3:0][15:0]   stick_r, stick_nxt;
  logic [1:0][15:0]   trig_r, trig_nxt;
  logic [1:0][5:0]    btn_r, btn_nxt;
  logic [5:0]         pend_r, pend_nxt;
  logic [COUNT_W-1:0] ss_r, ss_nxt, sf_r, sf_nxt;

  logic               accept;
  logic [15:0]        old_val;
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic               changed;
  logic [7:0]         btn_ext;
  logic               btn_flip;
  logic [COUNT_W-1:0] ss_inc, sf_inc;
  logic [5:0]         send_mask;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    old_val = (cmd_t'(in_cmd) == CMD_STICK) ? stick_r[{in_side, in_axis_sel}]
                                             : trig_r[in_side];
    diff    = $signed({in_sample[15], in_sample}) - $signed({old_val[15], old_val});
    mag     = diff[16] ? 17'(-diff) : 17'(diff);
    changed = mag > {2'b00, thr_r};
    btn_ext  = {2'b00, btn_r[in_side]};
    btn_flip = (in_button_index <= 3'd5) && (btn_ext[in_button_index] != in_pressed);
    ss_inc   = (ss_r == COUNT_MAX) ? ss_r : ss_r + 1'b1;
    sf_inc   = (sf_r == COUNT_MAX) ? sf_r : sf_r + 1'b1;
  end

  always_comb begin
    stick_nxt = stick_r;
    trig_nxt  = trig_r;
    btn_nxt   = btn_r;
    pend_nxt  = pend_r;
    ss_nxt    = ss_r;
    sf_nxt    = sf_r;
    q_push    = 1'b0;
    send_mask = pend_r;
    if (accept) begin
      case (cmd_t'(in_cmd))
        CMD_STICK: begin
          if (changed) begin
            stick_nxt[{in_side, in_axis_sel}] = in_sample;
            pend_nxt = pend_r | (6'h01 << in_side);
          end
        end
        CMD_TRIGGER: begin
          if (changed) begin
            trig_nxt[in_side] = in_sample;
            pend_nxt = pend_r | (6'h04 << in_side);
          end
        end
        CMD_BUTTON: begin
          if (btn_flip) begin
            btn_nxt[in_side] = btn_r[in_side] ^ 6'(8'h01 << in_button_index);
            pend_nxt = pend_r | (6'h10 << in_side);
          end
        end
        default: begin
          ss_nxt = ss_inc;
          sf_nxt = sf_inc;
          if (ss_inc > {1'b0, min_r}) begin
            if (sf_inc > {1'b0, max_r}) begin
              send_mask = pend_r | LEFT_GROUPS;
              q_push    = 1'b1;
              ss_nxt    = '0;
              sf_nxt    = '0;
              pend_nxt  = RIGHT_GROUPS;
            end else if (((pend_r & BUTTON_GROUPS) != '0) ||
                         ((pend_r != '0) && (ss_inc > {1'b0, analog_r}))) begin
              q_push   = 1'b1;
              ss_nxt   = '0;
              pend_nxt = '0;
            end
          end
        end
      endcase
    end
  end

  assign q_data.mask  = send_mask;
  assign q_data.stick = stick_r;
  assign q_data.trig  = trig_r;
  assign q_data.btn   = btn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= 15'd98;
      min_r    <= 10'd20;
      analog_r <= 10'd50;
      max_r    <= 10'd800;
      stick_r  <= '0;
      trig_r   <= '0;
      btn_r    <= '0;
      pend_r   <= '0;
      ss_r     <= '0;
      sf_r     <= '0;
    end else begin
      stick_r <= stick_nxt;
      trig_r  <= trig_nxt;
      btn_r   <= btn_nxt;
      pend_r  <= pend_nxt;
      ss_r    <= ss_nxt;
      sf_r    <= sf_nxt;
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD: thr_r    <= cfg_data;
          CFG_MIN_INT:   min_r    <= cfg_data[9:0];
          CFG_ANALOG:    analog_r <= cfg_data[9:0];
          CFG_MAX_INT:   max_r    <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/cdrp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdrp_back
// Walks the queued packet one byte per cycle into the output register; out_ready low holds it.
// ----------------------------------------------------------------------------
module cdrp_back
  import cdrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire snap_t      head,
  input  wire q_status_t  q_status,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_byte
);

  function automatic logic [7:0] stick_byte(input logic [15:0] v);
    logic [15:0] u;
    logic [23:0] p;
    u = v ^ 16'h8000;
    p = {u, 8'h00} - {8'h00, u};
    return p[23:16];
  endfunction

  function automatic logic [7:0] trig_byte(input logic [15:0] v);
    logic [22:0] p;
    p = {v[14:0], 8'h00} - {8'h00, v[14:0]};
    return v[15] ? 8'h00 : p[22:15];
  endfunction

  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic [NUM_SLOTS-1:0] en;
  logic                 has_next;
  logic [SLOT_W-1:0]    next_slot;
  logic [7:0]           cur_byte;
  logic                 load;

  always_comb begin
    en = {head.mask[5], head.mask[4], head.mask[3], head.mask[2],
          head.mask[1], head.mask[1], head.mask[0], head.mask[0], 1'b1};
    has_next  = 1'b0;
    next_slot = '0;
    for (int k = NUM_SLOTS - 1; k >= 1; k--) begin
      if ((SLOT_W'(k) > slot_r) && en[k]) begin
        has_next  = 1'b1;
        next_slot = SLOT_W'(k);
      end
    end
    case (slot_r)
      4'd0:    cur_byte = {2'b00, head.mask};
      4'd1:    cur_byte = stick_byte(head.stick[0]);
      4'd2:    cur_byte = stick_byte(head.stick[1]);
      4'd3:    cur_byte = stick_byte(head.stick[2]);
      4'd4:    cur_byte = stick_byte(head.stick[3]);
      4'd5:    cur_byte = trig_byte(head.trig[0]);
      4'd6:    cur_byte = trig_byte(head.trig[1]);
      4'd7:    cur_byte = {2'b00, head.btn[0]};
      4'd8:    cur_byte = {2'b00, head.btn[1]};
      default: cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    load          = !q_status.empty && (!out_valid_r || out_ready);
    q_pop         = load && !has_next;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      slot_nxt      = has_next ? next_slot : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= !has_next;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule
`default_nettype wire

/* rtl/core/change_driven_report_packetizer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// change_driven_report_packetizer_unit
// Tracks sticks, triggers and buttons and emits rate limited change packets.
// ----------------------------------------------------------------------------
// Input channel (in_*): setter items and one millisecond ticks, valid/ready.
// Setter items update stored values and pending groups in the cycle taken.
// A tick that sends captures a packet into a two-entry queue; in_ready drops
// only while that queue is full.
// Output channel (out_*): one packet byte per item, header first,
// out_last_byte on the final byte. The first byte passes through the queue
// and then the output register; a packet of n bytes (2 to 9) leaves one byte
// per cycle from the output register, walked by the back end, unless out_ready stalls it.
// Items are taken one per cycle while the queue has room.
// If the receiver stalls, the output register holds, the queue fills and
// then ticks and setters wait at in_ready.
// cfg_*: single cycle register writes, to be used while the block is idle; the block does not enforce this.
// Reset (rst_n, synchronous) restores register defaults, clears all values,
// pending groups, counters, queue and output; no clearing pass is needed.
// ----------------------------------------------------------------------------
module change_driven_report_packetizer_unit
  import cdrp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic               in_side,
  input  wire logic               in_axis_sel,
  input  wire logic [2:0]         in_button_index,
  input  wire logic               in_pressed,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last_byte
);

  q_status_t q_stat;
  logic      q_push;
  logic      q_pop;
  snap_t     q_wdata;
  snap_t     q_head;

  cdrp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_side         (in_side),
    .in_axis_sel     (in_axis_sel),
    .in_button_index (in_button_index),
    .in_pressed      (in_pressed),
    .in_sample       (in_sample),
    .q_status        (q_stat),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  cdrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_stat)
  );

  cdrp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .q_status      (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

`ifndef SYNTHESIS
  a_q_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_stat.empty)
    else $error("queue full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("packet pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("packet popped from empty queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last_byte))
    else $error("packet retired without last byte");
`endif

endmodule
`default_nettype wire
